>>> rtl/lbf_pkg.sv
package lbf_pkg;

	// One accepted input item.
	typedef struct packed {
		logic [7:0] text_byte;
		logic       is_final;
	} lbf_in_t;

	// One result item.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       line_overflowed;
	} lbf_out_t;

	// Special byte values.
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	// Tag lengths and the width of an index into a tag.
	localparam int OPEN_LEN  = 29;
	localparam int CLOSE_LEN = 30;
	localparam int TAG_KW    = 5;

	// Open tag, byte by byte. The close tag is the same with a slash after the '<'.
	localparam logic [7:0] OPEN_TAG [OPEN_LEN] = '{
		8'h3C, 8'h70, 8'h68, 8'h6F, 8'h74, 8'h6F, 8'h73, 8'h68, 8'h6F, 8'h70,
		8'h3A, 8'h44, 8'h6F, 8'h63, 8'h75, 8'h6D, 8'h65, 8'h6E, 8'h74, 8'h41,
		8'h6E, 8'h63, 8'h65, 8'h73, 8'h74, 8'h6F, 8'h72, 8'h73, 8'h3E
	};

	// Returns byte k of the open tag or of the close tag.
	function automatic logic [7:0] tag_char(input logic is_close,
		input logic [TAG_KW-1:0] k);
		logic [TAG_KW-1:0] j;
		logic [7:0]        c;
		begin
			j = (is_close && (k != '0)) ? k - TAG_KW'(1) : k;
			if (is_close && (k == TAG_KW'(1))) begin
				c = CH_SLASH;
			end else if (32'(j) < OPEN_LEN) begin
				c = OPEN_TAG[j];
			end else begin
				c = 8'h00;
			end
			return c;
		end
	endfunction

endpackage

>>> rtl/lbf_stream_if.sv
interface lbf_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/xml_block_line_filter.sv
// A streamed byte of an over-long line is shown on the output register in the
// cycle after it is accepted. At line end, a line that may be a tag is compared
// one tag byte at a time, each through a read state and a check state, and a
// kept line is sent byte by byte through a read state and a send state, both
// paced by the registered read port of the line buffer.
// Reset clears all control state; the line buffer is not cleared.
module xml_block_line_filter #(
	parameter int LINE_MAX = 63
) (
	input  logic         clk,
	input  logic         arst_n,
	lbf_stream_if.sink   din,
	lbf_stream_if.source dout
);
	import lbf_pkg::*;

	localparam int AW = $clog2(LINE_MAX + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP_RD,
		S_CMP_CHK,
		S_EMIT_RD,
		S_EMIT_SEND
	} state_t;

	state_t         state_q;
	logic [AW-1:0]  count_q;
	logic [AW-1:0]  first_q;
	logic [AW-1:0]  last_q;
	logic           seen_q;
	logic           waiting_q;
	logic           pass_q;
	logic [AW-1:0]  idx_q;
	logic [AW-1:0]  end_q;
	logic [AW-1:0]  cmp_first_q;
	logic [AW-1:0]  cmp_last_q;
	logic           flag_q;
	logic           fin_q;
	logic           tag_sel_q;
	logic           out_valid_q;
	lbf_out_t       out_q;

	logic           acc;
	logic [7:0]     b;
	logic           fin;
	logic           at_end;
	logic           content;
	logic [AW-1:0]  nfirst;
	logic [AW-1:0]  nlast;
	logic           nseen;
	logic           cand;
	logic [AW-1:0]  span_m1;
	logic           buf_full;
	logic [7:0]     rdata;
	logic           eq;
	logic [AW-1:0]  k_full;
	logic           out_free;
	logic           out_load;

	assign b        = din.data.text_byte;
	assign fin      = din.data.is_final;
	assign at_end   = (b == CH_NL) || fin;
	assign out_free = !out_valid_q || dout.ready;
	assign din.ready = (state_q == S_IDLE) && out_free;
	assign acc      = din.valid && din.ready;
	assign buf_full = (count_q == AW'(LINE_MAX));

	// The output register takes a new result on a streamed byte or a send step.
	assign out_load = (acc && pass_q && !waiting_q)
		|| ((state_q == S_EMIT_SEND) && out_free);

	// Content tracking including the byte now offered.
	assign content = !((b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_NL));
	assign nseen   = seen_q || content;
	assign nfirst  = (!seen_q && content) ? count_q : first_q;
	assign nlast   = content ? count_q : last_q;

	// Span test: a line can only be a tag if its content has the tag's length.
	assign span_m1 = waiting_q ? AW'(CLOSE_LEN - 1) : AW'(OPEN_LEN - 1);
	assign cand    = nseen && (nlast >= nfirst) && ((nlast - nfirst) == span_m1);

	// Line buffer; the line-end byte is stored too, one place past the line.
	lbf_ram #(
		.WIDTH (8),
		.DEPTH (LINE_MAX + 1)
	) u_ram (
		.clk   (clk),
		.we    (acc && !pass_q),
		.waddr (count_q),
		.wdata (b),
		.raddr (idx_q),
		.rdata (rdata)
	);

	assign k_full = idx_q - cmp_first_q;

	lbf_tag_cmp u_cmp (
		.is_close (tag_sel_q),
		.k        (k_full[TAG_KW-1:0]),
		.data     (rdata),
		.eq       (eq)
	);

	assign dout.valid = out_valid_q;
	assign dout.data  = out_q;

	// Sequencer: buffering, tag compare sweep and line send sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			first_q     <= '0;
			last_q      <= '0;
			seen_q      <= 1'b0;
			waiting_q   <= 1'b0;
			pass_q      <= 1'b0;
			idx_q       <= '0;
			end_q       <= '0;
			cmp_first_q <= '0;
			cmp_last_q  <= '0;
			flag_q      <= 1'b0;
			fin_q       <= 1'b0;
			tag_sel_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (pass_q) begin
							// Rest of an over-long line goes straight out, or is dropped while a close tag is awaited.
							if (!waiting_q) begin
								out_q <= '{out_byte: b, run_last: 1'b1,
									line_overflowed: 1'b1};
							end
							if (at_end) begin
								pass_q  <= 1'b0;
								count_q <= '0;
								first_q <= '0;
								last_q  <= '0;
								seen_q  <= 1'b0;
								if (fin) begin
									waiting_q <= 1'b0;
								end
							end
						end else if (!at_end && !buf_full) begin
							count_q <= count_q + AW'(1);
							first_q <= nfirst;
							last_q  <= nlast;
							seen_q  <= nseen;
						end else begin
							count_q <= '0;
							first_q <= '0;
							last_q  <= '0;
							seen_q  <= 1'b0;
							end_q   <= count_q;
							fin_q   <= fin;
							if (!at_end) begin
								// Buffer full: flush it flagged and stream the rest; while a close tag is awaited both are dropped.
								pass_q <= 1'b1;
								flag_q <= 1'b1;
								idx_q  <= '0;
								if (!waiting_q) begin
									state_q <= S_EMIT_RD;
								end
							end else if (waiting_q) begin
								if (fin) begin
									waiting_q <= 1'b0;
								end else if (cand) begin
									tag_sel_q   <= 1'b1;
									cmp_first_q <= nfirst;
									cmp_last_q  <= nlast;
									idx_q       <= nfirst;
									state_q     <= S_CMP_RD;
								end
							end else begin
								flag_q <= 1'b0;
								if (cand) begin
									tag_sel_q   <= 1'b0;
									cmp_first_q <= nfirst;
									cmp_last_q  <= nlast;
									idx_q       <= nfirst;
									state_q     <= S_CMP_RD;
								end else begin
									idx_q   <= '0;
									state_q <= S_EMIT_RD;
								end
							end
						end
					end
				end
				S_CMP_RD: begin
					state_q <= S_CMP_CHK;
				end
				S_CMP_CHK: begin
					if (!eq) begin
						// Not a tag: a waiting line is dropped, others are sent.
						idx_q   <= '0;
						state_q <= tag_sel_q ? S_IDLE : S_EMIT_RD;
					end else if (idx_q == cmp_last_q) begin
						waiting_q <= tag_sel_q ? 1'b0 : !fin_q;
						state_q   <= S_IDLE;
					end else begin
						idx_q   <= idx_q + AW'(1);
						state_q <= S_CMP_RD;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_SEND;
				end
				S_EMIT_SEND: begin
					if (out_free) begin
						out_q <= '{out_byte: rdata, run_last: (idx_q == end_q),
							line_overflowed: flag_q};
						if (idx_q == end_q) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + AW'(1);
							state_q <= S_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

>>> rtl/lbf_ram.sv
module lbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one read port with registered data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/lbf_tag_cmp.sv
module lbf_tag_cmp (
	input  logic                      is_close,
	input  logic [lbf_pkg::TAG_KW-1:0] k,
	input  logic [7:0]                data,
	output logic                      eq
);
	import lbf_pkg::*;

	// Shared compare unit: one buffered byte against one tag byte.
	assign eq = (data == tag_char(is_close, k));
endmodule

>>> rtl/lbf_checker.sv
module lbf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_run_last,
	input logic       out_overflowed
);
	// A stalled result stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte)
			&& $stable(out_run_last) && $stable(out_overflowed))
		else $error("result changed while stalled");

	// A new item is only taken when the output register can take a result.
	a_in_room: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && out_valid |-> out_ready)
		else $error("input ready while output register is blocked");

	// While a run is still being sent, no item is taken.
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_run_last |-> !in_ready)
		else $error("input ready in the middle of a run");

	// While a non-final result of a run is held, no item is accepted.
	a_run_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_run_last |-> !(in_valid && in_ready))
		else $error("item accepted while a run is pending");
endmodule

bind xml_block_line_filter lbf_checker u_lbf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (din.valid),
	.in_ready       (din.ready),
	.out_valid      (dout.valid),
	.out_ready      (dout.ready),
	.out_byte       (dout.data.out_byte),
	.out_run_last   (dout.data.run_last),
	.out_overflowed (dout.data.line_overflowed)
);
